/* rtl/fixed_frame_deframer_crc16_check_unit_macros.svh */
`ifndef FIXED_FRAME_DEFRAMER_CRC16_CHECK_UNIT_MACROS_SVH
`define FIXED_FRAME_DEFRAMER_CRC16_CHECK_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define FFDC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define FFDC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ffdc_pkg.sv */
package ffdc_pkg;

    // Frame geometry
    localparam int FRAME_BYTES = 8;
    localparam int WIN_DEPTH   = FRAME_BYTES - 1;
    localparam int FILL_W      = $clog2(FRAME_BYTES);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_DEPTH);

    // Marker bytes
    localparam logic [7:0] HEADER_BYTE  = 8'hFF;
    localparam logic [7:0] TRAILER_BYTE = 8'hFE;

    // CRC-16/MODBUS
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Operation codes
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Result kinds
    localparam logic KIND_TEXT  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // Reply codes
    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_OK   = 2'd1;
    localparam logic [1:0] REPLY_ERR  = 2'd2;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } ffdc_in_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  text_byte;
        logic [31:0] data_word;
        logic [15:0] received_crc;
        logic [15:0] computed_crc;
        logic        crc_ok;
        logic [1:0]  reply_code;
        logic [31:0] frame_total;
        logic [31:0] pass_total;
        logic [31:0] fail_total;
        logic [31:0] reply_total;
        logic        last;
    } ffdc_out_t;

    // Window shift line commands
    typedef struct packed {
        logic append;
        logic shift_in;
        logic pop;
        logic clear;
    } ffdc_win_ctrl_t;

    // Window shift line status
    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic [7:0]        head;
        logic [7:0]        next;
        logic [31:0]       data_word;
        logic [15:0]       rx_crc;
    } ffdc_win_stat_t;

    typedef struct packed {
        logic        busy;
        logic [15:0] crc;
    } ffdc_crc_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CRC,
        ST_SCAN
    } ffdc_state_t;

endpackage

/* rtl/fixed_frame_deframer_crc16_check_unit.sv */
// Byte-stream deframer for 8-byte frames (0xFF, four data bytes, CRC low, CRC high, 0xFE)
// with a CRC-16/MODBUS check, pass/fail/reply counters and an optional OK/ERR reply code.
// Bytes that open or extend a partial frame, and clear operations, are taken one per cycle
// with no result. A byte outside any frame gives its text result on the next cycle. The
// trailer byte of a frame starts the CRC unit, which works four data bits per cycle, and the
// frame result is registered once the CRC unit is done; the next byte is taken back in idle.
// A bad trailer drops the header and rescans the held bytes through the window
// shift line one byte per cycle: up to 7 text results, then a return to idle.
// Output backpressure stalls the input, the frame result and each rescanned byte alike.
`include "fixed_frame_deframer_crc16_check_unit_macros.svh"

module fixed_frame_deframer_crc16_check_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ffdc_pkg::ffdc_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ffdc_pkg::ffdc_out_t m_data,
    input  logic                cfg_we,
    input  logic                cfg_wdata
);
    import ffdc_pkg::*;

    ffdc_state_t    state_reg, state_next;
    ffdc_win_ctrl_t win_ctrl;
    ffdc_win_stat_t win_stat;
    ffdc_crc_stat_t crc_stat;

    logic        auto_reply_reg, auto_reply_next;
    logic        m_valid_reg, m_valid_next;
    ffdc_out_t   out_reg, out_next;
    logic [31:0] frame_cnt_reg, frame_cnt_next;
    logic [31:0] pass_cnt_reg,  pass_cnt_next;
    logic [31:0] fail_cnt_reg,  fail_cnt_next;
    logic [31:0] reply_cnt_reg, reply_cnt_next;

    logic       out_free;
    logic       s_accept;
    logic       scan_done;
    logic       crc_start;
    logic       cnt_clear;
    logic       emit_text;
    logic       emit_frame;
    logic [7:0] text_src;
    logic       text_last;
    logic       frame_ok;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign scan_done = (win_stat.fill == '0) || (win_stat.head == HEADER_BYTE);
    assign frame_ok  = (crc_stat.crc == win_stat.rx_crc);

    ffdc_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (win_ctrl),
        .rx_byte (s_data.rx_byte),
        .stat    (win_stat)
    );

    ffdc_crc_serial u_crc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (crc_start),
        .data_word (win_stat.data_word),
        .stat      (crc_stat)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_data.operation == OP_BYTE && win_stat.fill == FILL_FULL) begin
                    state_next = (s_data.rx_byte == TRAILER_BYTE) ? ST_CRC : ST_SCAN;
                end
            end
            ST_CRC: begin
                if (!crc_stat.busy && out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_ready    = 1'b0;
        win_ctrl   = '0;
        crc_start  = 1'b0;
        cnt_clear  = 1'b0;
        emit_text  = 1'b0;
        emit_frame = 1'b0;
        text_src   = s_data.rx_byte;
        text_last  = 1'b1;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = out_free;
                if (s_accept) begin
                    if (s_data.operation == OP_CLEAR) begin
                        cnt_clear = 1'b1;
                    end else if (win_stat.fill == '0) begin
                        if (s_data.rx_byte == HEADER_BYTE) begin
                            win_ctrl.append = 1'b1;
                        end else begin
                            emit_text = 1'b1;
                        end
                    end else if (win_stat.fill != FILL_FULL) begin
                        win_ctrl.append = 1'b1;
                    end else if (s_data.rx_byte == TRAILER_BYTE) begin
                        crc_start = 1'b1;
                    end else begin
                        win_ctrl.shift_in = 1'b1;
                    end
                end
            end
            ST_CRC: begin
                if (!crc_stat.busy && out_free) begin
                    emit_frame     = 1'b1;
                    win_ctrl.clear = 1'b1;
                end
            end
            ST_SCAN: begin
                if (!scan_done && out_free) begin
                    emit_text    = 1'b1;
                    text_src     = win_stat.head;
                    text_last    = (win_stat.fill == FILL_W'(1)) ||
                                   (win_stat.next == HEADER_BYTE);
                    win_ctrl.pop = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Update counters and build the result
    always_comb begin
        frame_cnt_next  = frame_cnt_reg;
        pass_cnt_next   = pass_cnt_reg;
        fail_cnt_next   = fail_cnt_reg;
        reply_cnt_next  = reply_cnt_reg;
        auto_reply_next = cfg_we ? cfg_wdata : auto_reply_reg;
        out_next        = out_reg;
        m_valid_next    = m_ready ? 1'b0 : m_valid_reg;

        if (cnt_clear) begin
            frame_cnt_next = '0;
            pass_cnt_next  = '0;
            fail_cnt_next  = '0;
            reply_cnt_next = '0;
        end else if (emit_frame) begin
            frame_cnt_next = frame_cnt_reg + 32'd1;
            if (frame_ok) begin
                pass_cnt_next = pass_cnt_reg + 32'd1;
            end else begin
                fail_cnt_next = fail_cnt_reg + 32'd1;
            end
            if (auto_reply_reg) begin
                reply_cnt_next = reply_cnt_reg + 32'd1;
            end
        end

        if (emit_text || emit_frame) begin
            m_valid_next          = 1'b1;
            out_next              = '0;
            out_next.frame_total  = frame_cnt_next;
            out_next.pass_total   = pass_cnt_next;
            out_next.fail_total   = fail_cnt_next;
            out_next.reply_total  = reply_cnt_next;
            if (emit_frame) begin
                out_next.kind         = KIND_FRAME;
                out_next.data_word    = win_stat.data_word;
                out_next.received_crc = win_stat.rx_crc;
                out_next.computed_crc = crc_stat.crc;
                out_next.crc_ok       = frame_ok;
                out_next.last         = 1'b1;
                if (auto_reply_reg) begin
                    out_next.reply_code = frame_ok ? REPLY_OK : REPLY_ERR;
                end else begin
                    out_next.reply_code = REPLY_NONE;
                end
            end else begin
                out_next.kind      = KIND_TEXT;
                out_next.text_byte = text_src;
                out_next.last      = text_last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            auto_reply_reg <= 1'b0;
            frame_cnt_reg  <= '0;
            pass_cnt_reg   <= '0;
            fail_cnt_reg   <= '0;
            reply_cnt_reg  <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            auto_reply_reg <= auto_reply_next;
            frame_cnt_reg  <= frame_cnt_next;
            pass_cnt_reg   <= pass_cnt_next;
            fail_cnt_reg   <= fail_cnt_next;
            reply_cnt_reg  <= reply_cnt_next;
        end
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // A held partial frame always opens with its header once idle
    `FFDC_ASSERT_NOW(a_win_head, aclk, aresetn, state_reg == ST_IDLE && win_stat.fill != '0, win_stat.head == HEADER_BYTE, "window does not start with header")
    // Trailer launches the CRC unit and the wait state together
    `FFDC_ASSERT_NEXT(a_crc_launch, aclk, aresetn, crc_start, crc_stat.busy && state_reg == ST_CRC, "CRC unit not running after trailer")
    // A frame result comes only from a full window
    `FFDC_ASSERT_NOW(a_frame_full, aclk, aresetn, emit_frame, win_stat.fill == FILL_FULL, "frame emitted from partial window")
    // Each rescanned byte shows up as a text transaction
    `FFDC_ASSERT_NEXT(a_scan_text, aclk, aresetn, emit_text && state_reg == ST_SCAN, m_valid && m_data.kind == KIND_TEXT, "rescanned byte not presented")

endmodule

/* rtl/ffdc_crc_serial.sv */
module ffdc_crc_serial (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [31:0]             data_word,
    output ffdc_pkg::ffdc_crc_stat_t stat
);
    import ffdc_pkg::*;

    localparam int NIBBLES = 8;
    localparam int CNT_W   = $clog2(NIBBLES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NIBBLES - 1);

    logic [15:0]      crc_reg,   crc_next;
    logic [31:0]      digit_reg, digit_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             busy_reg,  busy_next;

    // Advance the reflected CRC by four bits, LSB first
    function automatic logic [15:0] crc_nibble(input logic [15:0] c_in, input logic [3:0] d);
        logic [15:0] c;
        c = c_in;
        for (int i = 0; i < 4; i++) begin
            if (c[0] ^ d[i]) begin
                c = {1'b0, c[15:1]} ^ CRC_POLY;
            end else begin
                c = {1'b0, c[15:1]};
            end
        end
        return c;
    endfunction

    // Load bytes in reverse so that a right shift yields each byte low nibble first
    always_comb begin
        crc_next   = crc_reg;
        digit_next = digit_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (start) begin
            crc_next   = CRC_INIT;
            digit_next = {data_word[7:0], data_word[15:8], data_word[23:16], data_word[31:24]};
            cnt_next   = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            crc_next   = crc_nibble(crc_reg, digit_reg[3:0]);
            digit_next = {4'b0, digit_reg[31:4]};
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        crc_reg   <= crc_next;
        digit_reg <= digit_next;
    end

    assign stat.busy = busy_reg;
    assign stat.crc  = crc_reg;

endmodule

/* rtl/ffdc_window.sv */
module ffdc_window (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ffdc_pkg::ffdc_win_ctrl_t ctrl,
    input  logic [7:0]               rx_byte,
    output ffdc_pkg::ffdc_win_stat_t stat
);
    import ffdc_pkg::*;

    logic [7:0]        win_reg [WIN_DEPTH];
    logic [7:0]        win_next [WIN_DEPTH];
    logic [FILL_W-1:0] fill_reg, fill_next;

    // Clear, append at the fill point, or shift toward the head
    always_comb begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            win_next[i] = win_reg[i];
        end
        fill_next = fill_reg;
        if (ctrl.clear) begin
            fill_next = '0;
        end else if (ctrl.append) begin
            win_next[fill_reg] = rx_byte;
            fill_next          = fill_reg + 1'b1;
        end else if (ctrl.shift_in) begin
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                win_next[i] = win_reg[i+1];
            end
            win_next[WIN_DEPTH-1] = rx_byte;
        end else if (ctrl.pop) begin
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                win_next[i] = win_reg[i+1];
            end
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
        for (int i = 0; i < WIN_DEPTH; i++) begin
            win_reg[i] <= win_next[i];
        end
    end

    assign stat.fill      = fill_reg;
    assign stat.head      = win_reg[0];
    assign stat.next      = win_reg[1];
    assign stat.data_word = {win_reg[1], win_reg[2], win_reg[3], win_reg[4]};
    assign stat.rx_crc    = {win_reg[6], win_reg[5]};

endmodule
